/* design/dsib_pkg.sv */
// ----------------------------------------------------------------------------
// dsib_pkg
// Shared types and codes for the depth-sorted insert buffer.
// ----------------------------------------------------------------------------
package dsib_pkg;

  localparam int COORD_W   = 16;
  localparam int HANDLE_W  = 16;
  localparam int KEY_W     = 34;   // sum of three 32-bit squares
  localparam int OUT_KEY_W = 36;
  localparam int FILL_W    = 7;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  // What one cell hands to its farther-to-nearer neighbor.
  typedef struct packed {
    logic                stay;     // stored entry is farther than the new one
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } link_t;

endpackage

/* design/dsib_if.sv */
// ----------------------------------------------------------------------------
// dsib_if
// Request and response channels of the depth-sorted insert buffer.
// ----------------------------------------------------------------------------
interface dsib_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic signed [dsib_pkg::COORD_W-1:0] point_x;
  logic signed [dsib_pkg::COORD_W-1:0] point_y;
  logic signed [dsib_pkg::COORD_W-1:0] point_z;
  logic [dsib_pkg::HANDLE_W-1:0]       item_handle;
  logic [dsib_pkg::IDX_W-1:0]          read_index;

  modport source (output valid, op, point_x, point_y, point_z, item_handle, read_index,
                  input ready);
  modport sink   (input valid, op, point_x, point_y, point_z, item_handle, read_index,
                  output ready);
endinterface

interface dsib_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [dsib_pkg::HANDLE_W-1:0]  out_handle;
  logic [dsib_pkg::OUT_KEY_W-1:0] out_key;
  logic [dsib_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, status, out_handle, out_key, fill_count, input ready);
  modport sink   (input valid, status, out_handle, out_key, fill_count, output ready);
endinterface

/* design/depth_sorted_insert_buffer.sv */
// ----------------------------------------------------------------------------
// depth_sorted_insert_buffer
// Painter's-order buffer: entries kept sorted farthest to nearest by squared
// distance to the camera.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) carries op/point/item_handle/read_index; rsp (source) returns
//   status/out_handle/out_key/fill_count, exactly one rsp transfer per req.
//   Camera registers are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while the block is idle, and the block does not enforce it.
//   An index past camera_z is ignored.
// Sequence, one item at a time:
//   Insert passes the square stage, the sum stage and the chain update before rsp
//   valid; read passes the group mux stage and the final mux; clear and the unused
//   op go straight to commit. req.ready returns the cycle after commit.
// Chain:
//   DEPTH cells in a row. On insert every occupied cell compares its key with
//   the new one in parallel; farther cells hold, the first nearer-or-equal
//   cell takes the new entry and every cell after it takes its neighbor's.
// Reset clears the count, the camera and the control state; entry storage is
//   not cleared, since only positions below the count are ever read.
// A new req is taken once the previous item has committed, even while its
//   rsp still waits; the next commit holds until the rsp slot is free.
// ----------------------------------------------------------------------------
module depth_sorted_insert_buffer #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dsib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsib_pkg::COORD_W-1:0]    cfg_data,
  dsib_req_if.sink                        req,
  dsib_rsp_if.source                      rsp
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RD_N  = 1 << dsib_pkg::IDX_W;   // positions reachable by a read
  localparam int GRP   = 8;
  localparam int NGRP  = RD_N / GRP;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state, state_next;

  // camera registers
  logic signed [dsib_pkg::COORD_W-1:0] cam_x, cam_y, cam_z;

  // captured request
  logic [1:0]                          cur_op;
  logic signed [dsib_pkg::COORD_W-1:0] pt_x, pt_y, pt_z;
  logic [dsib_pkg::HANDLE_W-1:0]       new_handle;
  logic [dsib_pkg::IDX_W-1:0]          rd_index;

  logic [CW-1:0] count, count_next;
  logic [dsib_pkg::KEY_W-1:0] new_key;

  // response register
  logic                            out_valid;
  logic [1:0]                      out_status;
  logic [dsib_pkg::HANDLE_W-1:0]   out_handle;
  logic [dsib_pkg::OUT_KEY_W-1:0]  out_key;
  logic [dsib_pkg::FILL_W-1:0]     out_fill;

  logic commit;
  logic full;
  logic shift;

  // ---------------- camera config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dsib_pkg::CFG_CAMERA_X: cam_x <= cfg_data;
        dsib_pkg::CFG_CAMERA_Y: cam_y <= cfg_data;
        dsib_pkg::CFG_CAMERA_Z: cam_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- request capture ----------------
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur_op     <= req.op;
      pt_x       <= req.point_x;
      pt_y       <= req.point_y;
      pt_z       <= req.point_z;
      new_handle <= req.item_handle;
      rd_index   <= req.read_index;
    end
  end

  // ---------------- key pipeline ----------------
  dsib_keygen u_keygen (
    .clk   (clk),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .pt_x  (pt_x),
    .pt_y  (pt_y),
    .pt_z  (pt_z),
    .key   (new_key)
  );

  // ---------------- sorted chain ----------------
  dsib_pkg::link_t head;
  dsib_pkg::link_t links [DEPTH];

  // position 0 always sees a "farther" neighbor, so it can only take the new entry
  assign head = '{stay: 1'b1, key: '0, handle: '0};

  assign full  = (count == CW'(DEPTH));
  assign shift = commit && (cur_op == dsib_pkg::OP_INSERT) && !full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dsib_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .occupied   (count > CW'(i)),
      .new_key    (new_key),
      .new_handle (new_handle),
      .prev       ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link       (links[i])
    );
  end

  // ---------------- read path ----------------
  // Read-reachable positions padded to 64, then an 8-way group stage
  // registered ahead of the final 8-way select.
  logic [dsib_pkg::KEY_W-1:0]    rd_key    [RD_N];
  logic [dsib_pkg::HANDLE_W-1:0] rd_handle [RD_N];
  logic [dsib_pkg::KEY_W-1:0]    grp_key    [NGRP];
  logic [dsib_pkg::HANDLE_W-1:0] grp_handle [NGRP];

  for (genvar p = 0; p < RD_N; p++) begin : g_rd
    if (p < DEPTH) begin : g_live
      assign rd_key[p]    = links[p].key;
      assign rd_handle[p] = links[p].handle;
    end else begin : g_pad
      assign rd_key[p]    = '0;
      assign rd_handle[p] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_key[g]    <= rd_key[g * GRP + int'(rd_index[2:0])];
        grp_handle[g] <= rd_handle[g * GRP + int'(rd_index[2:0])];
      end
    end
  end

  logic [CW+dsib_pkg::IDX_W-1:0] idx_ext, cnt_ext;
  logic                          rd_hit;

  assign idx_ext = {CW'(0), rd_index};
  assign cnt_ext = {dsib_pkg::IDX_W'(0), count};
  assign rd_hit  = idx_ext < cnt_ext;

  // ---------------- control ----------------
  assign commit = (state == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.op)
            dsib_pkg::OP_INSERT: state_next = ST_SQ;
            dsib_pkg::OP_READ:   state_next = ST_RD;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_SQ:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_RD:   state_next = ST_DONE;
      ST_DONE: if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    case (cur_op)
      dsib_pkg::OP_INSERT: if (!full) count_next = count + CW'(1);
      dsib_pkg::OP_CLEAR:  count_next = '0;
      default: ;
    endcase
  end

  logic [CW+dsib_pkg::FILL_W-1:0] fill_ext;
  assign fill_ext = {dsib_pkg::FILL_W'(0), count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= dsib_pkg::STATUS_OK;
      out_handle <= '0;
      out_key    <= '0;
      out_fill   <= fill_ext[dsib_pkg::FILL_W-1:0];
      case (cur_op)
        dsib_pkg::OP_INSERT: if (full) out_status <= dsib_pkg::STATUS_FULL;
        dsib_pkg::OP_READ: begin
          if (rd_hit) begin
            out_handle <= grp_handle[rd_index[dsib_pkg::IDX_W-1:3]];
            out_key    <= dsib_pkg::OUT_KEY_W'(grp_key[rd_index[dsib_pkg::IDX_W-1:3]]);
          end else begin
            out_status <= dsib_pkg::STATUS_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.out_handle = out_handle;
  assign rsp.out_key    = out_key;
  assign rsp.fill_count = out_fill;

endmodule

/* design/dsib_keygen.sv */
// ----------------------------------------------------------------------------
// dsib_keygen
// Two-stage squared-distance pipeline: squares, then the three-term sum.
// ----------------------------------------------------------------------------
module dsib_keygen (
  input  logic                                clk,
  input  logic signed [dsib_pkg::COORD_W-1:0] cam_x,
  input  logic signed [dsib_pkg::COORD_W-1:0] cam_y,
  input  logic signed [dsib_pkg::COORD_W-1:0] cam_z,
  input  logic signed [dsib_pkg::COORD_W-1:0] pt_x,
  input  logic signed [dsib_pkg::COORD_W-1:0] pt_y,
  input  logic signed [dsib_pkg::COORD_W-1:0] pt_z,
  output logic [dsib_pkg::KEY_W-1:0]          key
);

  localparam int SQ_W = 2 * dsib_pkg::COORD_W;

  logic signed [dsib_pkg::COORD_W:0] diff [3];
  logic [dsib_pkg::COORD_W-1:0]      mag  [3];
  logic [SQ_W-1:0]                   sq   [3];

  always_comb begin
    diff[0] = {cam_x[dsib_pkg::COORD_W-1], cam_x} - {pt_x[dsib_pkg::COORD_W-1], pt_x};
    diff[1] = {cam_y[dsib_pkg::COORD_W-1], cam_y} - {pt_y[dsib_pkg::COORD_W-1], pt_y};
    diff[2] = {cam_z[dsib_pkg::COORD_W-1], cam_z} - {pt_z[dsib_pkg::COORD_W-1], pt_z};
    for (int i = 0; i < 3; i++) begin
      // |diff| never exceeds 65535, so it fits the coordinate width unsigned
      mag[i] = diff[i][dsib_pkg::COORD_W] ? dsib_pkg::COORD_W'(-diff[i])
                                          : diff[i][dsib_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= mag[i] * mag[i];
    end
    key <= dsib_pkg::KEY_W'(sq[0]) + dsib_pkg::KEY_W'(sq[1]) + dsib_pkg::KEY_W'(sq[2]);
  end

endmodule

/* design/dsib_cell.sv */
// ----------------------------------------------------------------------------
// dsib_cell
// One slot of the sorted chain: keeps, takes the new entry, or takes its
// farther neighbor's entry.
// ----------------------------------------------------------------------------
module dsib_cell (
  input  logic                          clk,
  input  logic                          shift,
  input  logic                          occupied,
  input  logic [dsib_pkg::KEY_W-1:0]    new_key,
  input  logic [dsib_pkg::HANDLE_W-1:0] new_handle,
  input  dsib_pkg::link_t               prev,
  output dsib_pkg::link_t               link
);

  logic [dsib_pkg::KEY_W-1:0]    key;
  logic [dsib_pkg::HANDLE_W-1:0] handle;

  assign link.stay   = occupied && (key > new_key);
  assign link.key    = key;
  assign link.handle = handle;

  always_ff @(posedge clk) begin
    if (shift && !link.stay) begin
      if (prev.stay) begin
        key    <= new_key;
        handle <= new_handle;
      end else begin
        key    <= prev.key;
        handle <= prev.handle;
      end
    end
  end

endmodule
